### src/sgr_pkg.sv
// Shared types and constants for the six-button gamepad reader.
`timescale 1ns / 1ps

package sgr_pkg;

  localparam int STEP_W = 3;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_CLEAR  = 3'd0;
  localparam step_t STEP_DETECT = 3'd1;
  localparam step_t STEP_DPAD   = 3'd2;
  localparam step_t STEP_PROBE  = 3'd3;
  localparam step_t STEP_EXTRA  = 3'd4;
  localparam step_t STEP_LAST   = 3'd5;

  localparam int BTN_W = 12;

  localparam int BIT_RIGHT = 0;
  localparam int BIT_LEFT  = 1;
  localparam int BIT_DOWN  = 2;
  localparam int BIT_UP    = 3;
  localparam int BIT_START = 4;
  localparam int BIT_A     = 5;
  localparam int BIT_B     = 6;
  localparam int BIT_C     = 7;
  localparam int BIT_MODE  = 8;
  localparam int BIT_X     = 9;
  localparam int BIT_Y     = 10;
  localparam int BIT_Z     = 11;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_THREE = 2'd1,
    KIND_SIX   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] th;
    logic [7:0] tr;
    logic [7:0] tl;
    logic [7:0] d3;
    logic [7:0] d2;
    logic [7:0] d1;
    logic [7:0] d0;
    logic [7:0] led;
  } pin_map_t;

  localparam pin_map_t PIN_MAP_A = '{
    th: 8'h10, tr: 8'h80, tl: 8'h04, d3: 8'h40,
    d2: 8'h20, d1: 8'h08, d0: 8'h02, led: 8'h01
  };

  localparam pin_map_t PIN_MAP_B = '{
    th: 8'h08, tr: 8'h40, tl: 8'h02, d3: 8'h20,
    d2: 8'h10, d1: 8'h04, d0: 8'h01, led: 8'h80
  };

endpackage

### src/sgr_pad.sv
// Per-pad decode: button word and kind update for one step, and the drive byte.
`timescale 1ns / 1ps

module sgr_pad (
  input  sgr_pkg::pin_map_t             pins,
  input  logic                          en,
  input  sgr_pkg::step_t                step,
  input  logic                          next_odd,
  input  logic [7:0]                    port,
  input  logic [sgr_pkg::BTN_W-1:0]     bits,
  input  sgr_pkg::kind_t                kind,
  output logic [sgr_pkg::BTN_W-1:0]     bits_next,
  output sgr_pkg::kind_t                kind_next,
  output logic [7:0]                    drive
);

  logic tr_low;
  logic tl_low;
  logic d3_low;
  logic d2_low;
  logic d1_low;
  logic d0_low;
  logic [sgr_pkg::BTN_W-1:0] add;

  assign tr_low = ~|(port & pins.tr);
  assign tl_low = ~|(port & pins.tl);
  assign d3_low = ~|(port & pins.d3);
  assign d2_low = ~|(port & pins.d2);
  assign d1_low = ~|(port & pins.d1);
  assign d0_low = ~|(port & pins.d0);

  always_comb begin
    add       = '0;
    bits_next = bits;
    kind_next = kind;
    if (en) begin
      case (step)
        sgr_pkg::STEP_CLEAR: begin
          bits_next = '0;
        end
        sgr_pkg::STEP_DETECT: begin
          add[sgr_pkg::BIT_START] = tr_low;
          add[sgr_pkg::BIT_A]     = tl_low;
          add[sgr_pkg::BIT_DOWN]  = d1_low;
          add[sgr_pkg::BIT_UP]    = d0_low;
          bits_next = bits | add;
          kind_next = (d3_low && d2_low) ? sgr_pkg::KIND_THREE : sgr_pkg::KIND_NONE;
        end
        sgr_pkg::STEP_DPAD: begin
          add[sgr_pkg::BIT_C]     = tr_low;
          add[sgr_pkg::BIT_B]     = tl_low;
          add[sgr_pkg::BIT_RIGHT] = d3_low;
          add[sgr_pkg::BIT_LEFT]  = d2_low;
          add[sgr_pkg::BIT_DOWN]  = d1_low;
          add[sgr_pkg::BIT_UP]    = d0_low;
          bits_next = bits | add;
        end
        sgr_pkg::STEP_PROBE: begin
          if (kind != sgr_pkg::KIND_NONE && d1_low && d0_low) begin
            kind_next = sgr_pkg::KIND_SIX;
          end
        end
        sgr_pkg::STEP_EXTRA: begin
          if (kind == sgr_pkg::KIND_SIX) begin
            add[sgr_pkg::BIT_MODE] = d3_low;
            add[sgr_pkg::BIT_X]    = d2_low;
            add[sgr_pkg::BIT_Y]    = d1_low;
            add[sgr_pkg::BIT_Z]    = d0_low;
          end
          bits_next = bits | add;
        end
        default: begin
          bits_next = bits;
        end
      endcase
    end
  end

  always_comb begin
    drive = 8'hFF;
    if (next_odd) begin
      drive = drive & ~pins.th;
    end
    if (kind_next != sgr_pkg::KIND_NONE) begin
      drive = drive & ~pins.led;
    end
  end

endmodule

### src/six_button_gamepad_reader.sv
// Top level of the two-pad six-button gamepad reader.
`timescale 1ns / 1ps

// Each accepted item is one port exchange at the current step of a six-step
// frame. The item is decoded in the cycle it is accepted and its result
// appears in the output register on the next cycle, so the block takes one
// item per cycle while the output is not stalled; in_ready drops only while a
// result waits on a stalled output. A failed transfer restarts the frame at
// step 0 and leaves the stored buttons and kinds as they were.

module six_button_gamepad_reader (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                port_a_in,
  input  logic [7:0]                port_b_in,
  input  logic                      xfer_ok,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                drive_a,
  output logic [7:0]                drive_b,
  output logic [sgr_pkg::BTN_W-1:0] buttons_a,
  output logic [sgr_pkg::BTN_W-1:0] buttons_b,
  output logic [1:0]                kind_a,
  output logic [1:0]                kind_b,
  output logic                      frame_done
);

  sgr_pkg::step_t            step;
  sgr_pkg::step_t            step_next;
  logic [sgr_pkg::BTN_W-1:0] bits_a;
  logic [sgr_pkg::BTN_W-1:0] bits_b;
  logic [sgr_pkg::BTN_W-1:0] bits_a_next;
  logic [sgr_pkg::BTN_W-1:0] bits_b_next;
  sgr_pkg::kind_t            pad_kind_a;
  sgr_pkg::kind_t            pad_kind_b;
  sgr_pkg::kind_t            pad_kind_a_next;
  sgr_pkg::kind_t            pad_kind_b_next;
  logic [7:0]                drive_a_next;
  logic [7:0]                drive_b_next;
  logic                      done_next;
  logic                      accept;

  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;

  always_comb begin
    step_next = sgr_pkg::STEP_CLEAR;
    done_next = 1'b0;
    if (xfer_ok && step <= sgr_pkg::STEP_LAST) begin
      if (step == sgr_pkg::STEP_LAST) begin
        done_next = 1'b1;
      end else begin
        step_next = step + sgr_pkg::step_t'(1);
      end
    end
  end

  sgr_pad u_pad_a (
    .pins      (sgr_pkg::PIN_MAP_A),
    .en        (xfer_ok),
    .step      (step),
    .next_odd  (step_next[0]),
    .port      (port_a_in),
    .bits      (bits_a),
    .kind      (pad_kind_a),
    .bits_next (bits_a_next),
    .kind_next (pad_kind_a_next),
    .drive     (drive_a_next)
  );

  sgr_pad u_pad_b (
    .pins      (sgr_pkg::PIN_MAP_B),
    .en        (xfer_ok),
    .step      (step),
    .next_odd  (step_next[0]),
    .port      (port_b_in),
    .bits      (bits_b),
    .kind      (pad_kind_b),
    .bits_next (bits_b_next),
    .kind_next (pad_kind_b_next),
    .drive     (drive_b_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= sgr_pkg::STEP_CLEAR;
      bits_a     <= '0;
      bits_b     <= '0;
      pad_kind_a <= sgr_pkg::KIND_NONE;
      pad_kind_b <= sgr_pkg::KIND_NONE;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        step       <= step_next;
        bits_a     <= bits_a_next;
        bits_b     <= bits_b_next;
        pad_kind_a <= pad_kind_a_next;
        pad_kind_b <= pad_kind_b_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      drive_a    <= drive_a_next;
      drive_b    <= drive_b_next;
      buttons_a  <= bits_a_next;
      buttons_b  <= bits_b_next;
      kind_a     <= pad_kind_a_next;
      kind_b     <= pad_kind_b_next;
      frame_done <= done_next;
    end
  end

endmodule
